/* sv/bb3c_pkg.sv */
// shared types, constants and a reciprocal helper function for the 3x3 clipped box blur
`default_nettype none
package bb3c_pkg;

    // widest row the line stores hold
    localparam int MAX_WIDTH_DEF = 4096;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam int CFG_DATA_W = 16;
    localparam int IMG_W_W = 13;
    localparam int IMG_H_W = 16;
    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    // reciprocal scaling for the rounded divide
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W = 20;
    localparam int NUM_W = 13;
    localparam int PROD_W = NUM_W + RECIP_W;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_in_run;
        logic       end_of_image;
    } pix_out_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // one output to compute: the 3x3 window plus which rows and columns count
    typedef struct packed {
        rgb_t [8:0] win;
        logic [2:0] rmask;
        logic [2:0] cmask;
        logic       last;
        logic       eoi;
    } job_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_READ,
        FR_EMIT
    } fr_state_t;

    // ceil(2^20 / (2n)) for n = 1..9
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
        logic [RECIP_W-1:0] m;
        unique case (n)
            4'd1: m = 20'd524288;
            4'd2: m = 20'd262144;
            4'd3: m = 20'd174763;
            4'd4: m = 20'd131072;
            4'd5: m = 20'd104858;
            4'd6: m = 20'd87382;
            4'd7: m = 20'd74899;
            4'd8: m = 20'd65536;
            4'd9: m = 20'd58255;
            default: m = 20'd524288;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

/* sv/bb3c_ram.sv */
// generic simple dual port ram with registered read
`default_nettype none
module bb3c_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* sv/bb3c_queue.sv */
// short job queue between the pixel front and the averaging back
`default_nettype none
module bb3c_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire bb3c_pkg::job_t    push_data,
    input  wire logic              pop,
    output bb3c_pkg::job_t         pop_data,
    output bb3c_pkg::q_status_t    status
);
    bb3c_pkg::job_t                    q_mem [bb3c_pkg::QUEUE_DEPTH];
    logic [bb3c_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bb3c_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bb3c_pkg::QUEUE_AW:0]       count_reg, count_next;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign pop_data     = q_mem[rd_ptr_reg];
    assign status.full  = (count_reg == (bb3c_pkg::QUEUE_AW+1)'(bb3c_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
endmodule
`default_nettype wire

/* sv/bb3c_front.sv */
// front: takes pixels, keeps line stores and window, queues output jobs
`default_nettype none
module bb3c_front #(
    parameter int MAX_WIDTH = bb3c_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire bb3c_pkg::pix_in_t                 s_data,
    input  wire logic                              cfg_we,
    input  wire logic [bb3c_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bb3c_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                   q_push,
    output bb3c_pkg::job_t                         q_data,
    input  wire bb3c_pkg::q_status_t               q_status
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    bb3c_pkg::fr_state_t state_reg, state_next;

    logic [bb3c_pkg::IMG_W_W-1:0] width_reg;
    logic [bb3c_pkg::IMG_H_W-1:0] height_reg;
    logic [CW-1:0]                col_reg, col_next;
    logic [bb3c_pkg::IMG_H_W-1:0] row_reg, row_next;
    logic [CW-1:0]                cur_col_reg;
    logic [bb3c_pkg::IMG_H_W-1:0] cur_row_reg;
    bb3c_pkg::rgb_t               pix_reg;
    bb3c_pkg::rgb_t [8:0]         win_reg;
    logic [3:0]                   en_reg, en_next;
    logic [3:0]                   last_reg;
    logic [2:0]                   rm0_reg, rm1_reg, cma_reg, cmb_reg;
    logic [1:0]                   slot_reg, slot_next;

    logic [CW-1:0]                eff_w;
    logic [bb3c_pkg::IMG_H_W-1:0] eff_h;
    logic                         accept, cfg_hit, col_wrap, row_wrap;
    logic                         slot_adv;
    logic                         p0, p1, ca, cb;
    logic [23:0]                  older_rd, newer_rd;

    // effective image size
    always_comb begin
        if (width_reg == '0) begin
            eff_w = CW'(1);
        end else if (width_reg > bb3c_pkg::IMG_W_W'(MAX_WIDTH)
                     && MAX_WIDTH < (1 << bb3c_pkg::IMG_W_W)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(width_reg);
        end
        eff_h = (height_reg == '0) ? bb3c_pkg::IMG_H_W'(1) : height_reg;
    end

    assign accept  = s_valid && s_ready;
    assign cfg_hit = cfg_we && (cfg_index == bb3c_pkg::REG_IMAGE_WIDTH
                                || cfg_index == bb3c_pkg::REG_IMAGE_HEIGHT);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bb3c_pkg::IMAGE_WIDTH_RST;
            height_reg <= bb3c_pkg::IMAGE_HEIGHT_RST;
        end else if (cfg_we) begin
            if (cfg_index == bb3c_pkg::REG_IMAGE_WIDTH) begin
                width_reg <= cfg_data[bb3c_pkg::IMG_W_W-1:0];
            end else if (cfg_index == bb3c_pkg::REG_IMAGE_HEIGHT) begin
                height_reg <= cfg_data[bb3c_pkg::IMG_H_W-1:0];
            end
        end
    end

    // raster position of the next pixel
    assign col_wrap = ({1'b0, col_reg} + 1'b1) >= {1'b0, eff_w};
    assign row_wrap = ({1'b0, row_reg} + 1'b1) >= {1'b0, eff_h};

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores
    bb3c_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older (
        .aclk  (aclk),
        .we    (state_reg == bb3c_pkg::FR_READ),
        .waddr (cur_col_reg[AW-1:0]),
        .wdata (newer_rd),
        .re    (accept),
        .raddr (col_reg[AW-1:0]),
        .rdata (older_rd)
    );

    bb3c_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer (
        .aclk  (aclk),
        .we    (state_reg == bb3c_pkg::FR_READ),
        .waddr (cur_col_reg[AW-1:0]),
        .wdata (pix_reg),
        .re    (accept),
        .raddr (col_reg[AW-1:0]),
        .rdata (newer_rd)
    );

    // which outputs this pixel releases
    always_comb begin
        p0 = (cur_row_reg != '0);
        p1 = ({1'b0, cur_row_reg} + 1'b1) == {1'b0, eff_h};
        ca = (cur_col_reg != '0);
        cb = ({1'b0, cur_col_reg} + 1'b1) == {1'b0, eff_w};
        en_next = {p1 && cb, p1 && ca, p0 && cb, p0 && ca};
    end

    // capture pixel, window shift and job descriptors
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg     <= s_data;
            cur_col_reg <= col_reg;
            cur_row_reg <= row_reg;
        end
        if (state_reg == bb3c_pkg::FR_READ) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= older_rd;
            win_reg[5] <= newer_rd;
            win_reg[8] <= pix_reg;
            en_reg   <= en_next;
            last_reg <= {en_next[3], en_next[2] && !en_next[3],
                         en_next[1] && !(|en_next[3:2]), en_next[0] && !(|en_next[3:1])};
            rm0_reg  <= {2'b11, cur_row_reg > bb3c_pkg::IMG_H_W'(1)};
            rm1_reg  <= {1'b1, p0, 1'b0};
            cma_reg  <= {2'b11, cur_col_reg > CW'(1)};
            cmb_reg  <= {1'b1, ca, 1'b0};
        end
    end

    // state and slot registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bb3c_pkg::FR_IDLE;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    assign slot_adv = !en_reg[slot_reg] || !q_status.full;

    // next state
    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            bb3c_pkg::FR_IDLE: begin
                if (accept) begin
                    state_next = bb3c_pkg::FR_READ;
                end
            end
            bb3c_pkg::FR_READ: begin
                slot_next  = '0;
                state_next = (|en_next) ? bb3c_pkg::FR_EMIT : bb3c_pkg::FR_IDLE;
            end
            bb3c_pkg::FR_EMIT: begin
                if (slot_adv) begin
                    slot_next = slot_reg + 1'b1;
                    if (slot_reg == 2'd3) begin
                        state_next = bb3c_pkg::FR_IDLE;
                    end
                end
            end
            default: state_next = bb3c_pkg::FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = (state_reg == bb3c_pkg::FR_IDLE);
        q_push       = (state_reg == bb3c_pkg::FR_EMIT) && en_reg[slot_reg]
                       && !q_status.full;
        q_data.win   = win_reg;
        q_data.rmask = slot_reg[1] ? rm1_reg : rm0_reg;
        q_data.cmask = slot_reg[0] ? cmb_reg : cma_reg;
        q_data.last  = last_reg[slot_reg];
        q_data.eoi   = (slot_reg == 2'd3);
    end
endmodule
`default_nettype wire

/* sv/bb3c_back.sv */
// back: sums the clipped window and divides by the neighbor count
`default_nettype none
module bb3c_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire bb3c_pkg::job_t        q_data,
    input  wire bb3c_pkg::q_status_t   q_status,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bb3c_pkg::pix_out_t         m_data
);
    logic                                      adv;
    logic                                      s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [2:0][bb3c_pkg::NUM_W-1:0]           s1_num_reg;
    logic [bb3c_pkg::RECIP_W-1:0]              s1_m_reg;
    logic                                      s1_last_reg, s1_eoi_reg;
    logic [2:0][bb3c_pkg::PROD_W-1:0]          s2_prod_reg;
    logic                                      s2_last_reg, s2_eoi_reg;
    bb3c_pkg::pix_out_t                        out_reg;

    logic [11:0]                               sum_r, sum_g, sum_b;
    logic [1:0]                                nr, nc;
    logic [3:0]                                n;

    // whole pipeline moves when the output slot is free
    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = adv && !q_status.empty;

    // masked window sums and neighbor count
    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < 9; k++) begin
            if (q_data.rmask[k/3] && q_data.cmask[k%3]) begin
                sum_r = sum_r + 12'(q_data.win[k].red);
                sum_g = sum_g + 12'(q_data.win[k].green);
                sum_b = sum_b + 12'(q_data.win[k].blue);
            end
        end
        nr = 2'($countones(q_data.rmask));
        nc = 2'($countones(q_data.cmask));
        n  = 4'(nr * nc);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= !q_status.empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // numerator 2*sum + n, reciprocal of 2n, product, final shift
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_num_reg[0] <= {sum_r, 1'b0} + bb3c_pkg::NUM_W'(n);
            s1_num_reg[1] <= {sum_g, 1'b0} + bb3c_pkg::NUM_W'(n);
            s1_num_reg[2] <= {sum_b, 1'b0} + bb3c_pkg::NUM_W'(n);
            s1_m_reg      <= bb3c_pkg::recip(n);
            s1_last_reg   <= q_data.last;
            s1_eoi_reg    <= q_data.eoi;
            for (int i = 0; i < 3; i++) begin
                s2_prod_reg[i] <= bb3c_pkg::PROD_W'(s1_num_reg[i])
                                  * bb3c_pkg::PROD_W'(s1_m_reg);
            end
            s2_last_reg <= s1_last_reg;
            s2_eoi_reg  <= s1_eoi_reg;
            out_reg.out_red      <= s2_prod_reg[0][bb3c_pkg::RECIP_SHIFT +: 8];
            out_reg.out_green    <= s2_prod_reg[1][bb3c_pkg::RECIP_SHIFT +: 8];
            out_reg.out_blue     <= s2_prod_reg[2][bb3c_pkg::RECIP_SHIFT +: 8];
            out_reg.last_in_run  <= s2_last_reg;
            out_reg.end_of_image <= s2_eoi_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule
`default_nettype wire

/* sv/box_blur_3x3_clipped.sv */
// top level: 3x3 clipped box blur over an rgb pixel stream
//
//  channel | ports                          | carries
//  --------+--------------------------------+-----------------------------------
//  input   | s_valid s_ready s_data         | one rgb pixel in raster order
//  result  | m_valid m_ready m_data         | blurred pixel, run and image flags
//  config  | cfg_we cfg_index cfg_data      | image width (0), image height (1)
//
//  the front reads the line stores as it takes a pixel, then updates the window and
//  checks the four output slots in turn if results follow, stalling on a full queue.
//  the back is a 3 stage pipeline: window sum, reciprocal multiply, output register.
//  reset clears counters, state and valid bits; line stores need no clearing.
//  a full job queue stalls the front; a stalled result stalls the back, then the front.
`default_nettype none
module box_blur_3x3_clipped #(
    parameter int MAX_WIDTH = bb3c_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire bb3c_pkg::pix_in_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output bb3c_pkg::pix_out_t                     m_data,
    input  wire logic                              cfg_we,
    input  wire logic [bb3c_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bb3c_pkg::CFG_DATA_W-1:0]   cfg_data
);
    logic                  q_push, q_pop;
    bb3c_pkg::job_t        q_in, q_out;
    bb3c_pkg::q_status_t   q_status;

    // pixel front
    bb3c_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_status  (q_status)
    );

    // job queue
    bb3c_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    // averaging back
    bb3c_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_data   (q_out),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_status.full))
        else $error("job pushed into full queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_status.empty))
        else $error("job popped from empty queue");

    // bottom-right pixel always closes its run
    a_eoi_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.end_of_image |-> m_data.last_in_run)
        else $error("end of image without last in run");

    // front takes one pixel at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front accepted back to back requests");
endmodule
`default_nettype wire

/* bench/tb_box_blur_3x3_clipped.sv */
// self-checking bench for the 3x3 clipped box blur: blur predictor, random images, backpressure
module tb_box_blur_3x3_clipped;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes past the register list, writes there are ignored
    localparam logic [bb3c_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [bb3c_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int LINE_DEPTH = bb3c_pkg::MAX_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 24;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    bb3c_pkg::pix_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    bb3c_pkg::pix_out_t m_data;
    logic cfg_we = 1'b0;
    logic [bb3c_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bb3c_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    box_blur_3x3_clipped dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [23:0] older_line [LINE_DEPTH];
    logic [23:0] newer_line [LINE_DEPTH];
    logic [23:0] win [3][3];
    int col_pos = 0;
    int row_pos = 0;
    logic [bb3c_pkg::IMG_W_W-1:0] width_reg = bb3c_pkg::IMAGE_WIDTH_RST;
    logic [bb3c_pkg::IMG_H_W-1:0] height_reg = bb3c_pkg::IMAGE_HEIGHT_RST;

    bb3c_pkg::pix_out_t blurred_q [$];
    int fail_count = 0;
    bit idle_on = 1'b1;
    int hold_gen = 0;

    // rounded clipped mean at one output position
    function automatic bb3c_pkg::pix_out_t blur_at(int orow, int ocol, int r, int c,
                                                   int wd, int ht);
        int sr, sg, sb, n, y, x, wr, wc;
        bb3c_pkg::pix_out_t res;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            y = orow + dy;
            wr = y - (r - 2);
            if (y < 0 || y >= ht || wr < 0 || wr > 2) continue;
            for (int dx = -1; dx <= 1; dx++) begin
                x = ocol + dx;
                wc = x - (c - 2);
                if (x < 0 || x >= wd || wc < 0 || wc > 2) continue;
                sr += win[wr][wc][23:16];
                sg += win[wr][wc][15:8];
                sb += win[wr][wc][7:0];
                n++;
            end
        end
        if (n == 0) n = 1;
        res.out_red = 8'((2 * sr + n) / (2 * n));
        res.out_green = 8'((2 * sg + n) / (2 * n));
        res.out_blue = 8'((2 * sb + n) / (2 * n));
        res.last_in_run = 1'b0;
        res.end_of_image = (orow == ht - 1 && ocol == wd - 1);
        return res;
    endfunction

    // update line stores and window, queue the blurred pixels this request releases
    task automatic predict_blur(input bb3c_pkg::pix_in_t p);
        int wd, ht, c, r, k, orow;
        logic [23:0] px, a, b;
        bb3c_pkg::pix_out_t res [4];
        wd = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg));
        ht = (height_reg == 0) ? 1 : int'(height_reg);
        c = col_pos;
        r = row_pos;
        k = 0;
        if (c >= wd) c = 0;
        if (r >= ht) r = 0;
        px = {p.in_red, p.in_green, p.in_blue};
        a = older_line[c];
        b = newer_line[c];
        older_line[c] = b;
        newer_line[c] = px;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = a;
        win[1][2] = b;
        win[2][2] = px;
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 0) begin
                if (r < 1) continue;
                orow = r - 1;
            end else begin
                if (r != ht - 1) continue;
                orow = r;
            end
            if (c >= 1) begin
                res[k] = blur_at(orow, c - 1, r, c, wd, ht);
                k++;
            end
            if (c == wd - 1) begin
                res[k] = blur_at(orow, c, r, c, wd, ht);
                k++;
            end
        end
        if (k > 0) res[k - 1].last_in_run = 1'b1;
        for (int i = 0; i < k; i++) blurred_q.push_back(res[i]);
        if (c + 1 >= wd) begin
            col_pos = 0;
            row_pos = (r + 1 >= ht) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // send one pixel request, with random gaps before it
    task automatic send_pixel(input bb3c_pkg::pix_in_t p);
        if (idle_on && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 50);
        end
        s_valid <= 1'b1;
        s_data <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_blur(p);
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++) send_pixel(bb3c_pkg::pix_in_t'($urandom));
    endtask

    // drop valid and let everything in flight come out
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (blurred_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bb3c_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bb3c_pkg::CFG_DATA_W-1:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == bb3c_pkg::REG_IMAGE_WIDTH) begin
            width_reg = val[bb3c_pkg::IMG_W_W-1:0];
        end else if (idx == bb3c_pkg::REG_IMAGE_HEIGHT) begin
            height_reg = val;
        end
        if (idx == bb3c_pkg::REG_IMAGE_WIDTH || idx == bb3c_pkg::REG_IMAGE_HEIGHT) begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(bb3c_pkg::REG_IMAGE_WIDTH, bb3c_pkg::CFG_DATA_W'(w));
        write_reg(bb3c_pkg::REG_IMAGE_HEIGHT, bb3c_pkg::CFG_DATA_W'(h));
    endtask

    // default width after reset, start of a single row
    task automatic test_reset_width;
        write_reg(bb3c_pkg::REG_IMAGE_HEIGHT, 16'd1);
        send_random_pixels(24);
    endtask

    // pixel extremes, zero and oversize registers, ignored indexes
    task automatic test_extremes;
        set_size(1, 1);
        send_pixel('0);
        send_pixel('1);
        set_size(0, 0);
        send_pixel('{8'hff, 8'h00, 8'hff});
        set_size(3, 3);
        for (int i = 0; i < 9; i++) begin
            send_pixel((i % 2) ? bb3c_pkg::pix_in_t'('1) : bb3c_pkg::pix_in_t'('0));
        end
        set_size(2, 65535);
        send_random_pixels(3);
        write_reg(REG_SPARE_A, 16'hffff);
        write_reg(REG_SPARE_B, 16'h0000);
        send_random_pixels(5);
        set_size(8191, 1);
        send_random_pixels(8);
        set_size(1, 5);
        send_random_pixels(5);
        set_size(5, 1);
        send_random_pixels(5);
    endtask

    // random small images, some cut short by a restart, some sent twice over
    task automatic test_random_images;
        int sent, w, h, n;
        sent = 0;
        while (sent < 160) begin
            w = $urandom_range(9, 1);
            h = $urandom_range(6, 1);
            set_size(w, h);
            n = w * h;
            if ($urandom_range(99) < 20) n = $urandom_range(w * h, 1);
            else if ($urandom_range(99) < 25) n = 2 * w * h;
            send_random_pixels(n);
            sent += n;
        end
    endtask

    // back to back on both sides
    task automatic test_no_idle;
        idle_on = 1'b0;
        set_size(8, 5);
        send_random_pixels(40);
        drain();
        idle_on = 1'b1;
    endtask

    // receiver stalls long while pixels keep coming
    task automatic test_backpressure;
        set_size(8, 6);
        hold_gen++;
        send_random_pixels(48);
    endtask

    // receiver: random ready, long hold-offs, and result checking
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (blurred_q.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, m_data);
                fail_count++;
            end else begin
                bb3c_pkg::pix_out_t e;
                e = blurred_q.pop_front();
                if (e.out_red !== m_data.out_red || e.out_green !== m_data.out_green ||
                    e.out_blue !== m_data.out_blue || e.last_in_run !== m_data.last_in_run ||
                    e.end_of_image !== m_data.end_of_image) begin
                    $display("%0t mismatch: expected %h %h %h %b %b, actual %h %h %h %b %b",
                             $time, e.out_red, e.out_green, e.out_blue, e.last_in_run,
                             e.end_of_image, m_data.out_red, m_data.out_green,
                             m_data.out_blue, m_data.last_in_run, m_data.end_of_image);
                    fail_count++;
                end
            end
        end
        if (hold_seen != hold_gen) begin
            hold_seen = hold_gen;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < 23);
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_width();
        test_extremes();
        test_random_images();
        test_no_idle();
        test_backpressure();
        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
sv/bb3c_pkg.sv
sv/bb3c_ram.sv
sv/bb3c_queue.sv
sv/bb3c_front.sv
sv/bb3c_back.sv
sv/box_blur_3x3_clipped.sv
bench/tb_box_blur_3x3_clipped.sv
